// File: rtl/take_comp_crossfade_mixer_unit_macros.svh
// assertion macros for the crossfade mixer
`ifndef TAKE_COMP_CROSSFADE_MIXER_UNIT_MACROS_SVH
`define TAKE_COMP_CROSSFADE_MIXER_UNIT_MACROS_SVH
`ifndef SYNTH
`define TCM_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("tcm assertion failed");
`define TCM_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("tcm assertion failed");
`else
`define TCM_ASSERT_IMP(lbl, ante, cons)
`define TCM_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// File: rtl/tcm_pkg.sv
// package: types, constants and gain table of the crossfade mixer
package tcm_pkg;
	localparam int SAMPLE_BITS = 24;
	localparam int TAKES = 4;
	localparam int MAX_SECTIONS_DEF = 16;
	localparam int POS_W = 28;
	localparam int HW_W = 12;
	localparam int CNT_CFG_W = 5;
	localparam int PRES_W = 4;
	localparam int SLOT_W = 4;
	localparam int TAKE_W = 2;
	localparam int CFG_IDX_W = 2;
	localparam int GAIN_W = 16;
	localparam int IDX_W = 7;
	localparam int FADE_STEPS = 64;
	localparam int NPH_W = 13;
	localparam int DNUM_W = 20;
	localparam int DDEN_W = 13;
	localparam logic [GAIN_W-1:0] GAIN_ONE = 16'd32768;
	localparam logic [POS_W-1:0] POS_MAX = '1;

	localparam logic [CFG_IDX_W-1:0] CFG_HALF_WINDOW = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SECTION_COUNT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_LENGTH = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_TAKE_PRESENT = 2'd3;

	localparam logic KIND_ENTRY = 1'b0;
	localparam logic KIND_FRAME = 1'b1;

	localparam logic [GAIN_W-1:0] SINE_TBL [0:64] = '{
		16'd0, 16'd804, 16'd1608, 16'd2411, 16'd3212, 16'd4011, 16'd4808, 16'd5602,
		16'd6393, 16'd7180, 16'd7962, 16'd8740, 16'd9512, 16'd10279, 16'd11039, 16'd11793,
		16'd12540, 16'd13279, 16'd14010, 16'd14733, 16'd15447, 16'd16151, 16'd16846,
		16'd17531, 16'd18205, 16'd18868, 16'd19520, 16'd20160, 16'd20788, 16'd21403,
		16'd22006, 16'd22595, 16'd23170, 16'd23732, 16'd24279, 16'd24812, 16'd25330,
		16'd25833, 16'd26320, 16'd26791, 16'd27246, 16'd27684, 16'd28106, 16'd28511,
		16'd28899, 16'd29269, 16'd29622, 16'd29957, 16'd30274, 16'd30572, 16'd30853,
		16'd31114, 16'd31357, 16'd31581, 16'd31786, 16'd31972, 16'd32138, 16'd32286,
		16'd32413, 16'd32522, 16'd32610, 16'd32679, 16'd32729, 16'd32758, 16'd32768
	};

	typedef struct packed {
		logic kind;
		logic [SLOT_W-1:0] entry_slot;
		logic [POS_W-1:0] entry_start;
		logic [POS_W-1:0] entry_end;
		logic [TAKE_W-1:0] entry_take;
		logic signed [SAMPLE_BITS-1:0] sample_take0;
		logic signed [SAMPLE_BITS-1:0] sample_take1;
		logic signed [SAMPLE_BITS-1:0] sample_take2;
		logic signed [SAMPLE_BITS-1:0] sample_take3;
	} in_item_t;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] mixed_sample;
		logic clipped;
		logic past_end;
	} out_item_t;

	typedef struct packed {
		logic [POS_W-1:0] start;
		logic [POS_W-1:0] stop;
		logic [TAKE_W-1:0] take;
	} entry_t;

	typedef struct packed {
		logic start;
		logic [DNUM_W-1:0] num;
		logic [DDEN_W-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic done;
		logic [IDX_W-1:0] quot;
	} div_rsp_t;
endpackage

// File: rtl/tcm_cell.sv
// one section cell of the rotating section ring
module tcm_cell import tcm_pkg::*; (
	input logic clk,
	input logic shift,
	input logic load,
	input entry_t load_entry,
	input entry_t from_next,
	output entry_t entry
);
	entry_t entry_q;

	always_ff @(posedge clk) begin
		if (load) begin
			entry_q <= load_entry;
		end else if (shift) begin
			entry_q <= from_next;
		end
	end

	assign entry = entry_q;
endmodule

// File: rtl/tcm_div.sv
// fade index divider, one quotient bit per cycle
module tcm_div import tcm_pkg::*; (
	input logic clk,
	input logic arst_n,
	input div_req_t req,
	output div_rsp_t rsp
);
	logic run_q;
	logic done_q;
	logic [2:0] cnt_q;
	logic [DNUM_W-1:0] rem_q;
	logic [DNUM_W-2:0] dsh_q;
	logic [IDX_W-1:0] quot_q;
	logic ge;

	assign ge = rem_q >= {1'b0, dsh_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				run_q <= 1'b1;
				cnt_q <= 3'(IDX_W - 1);
			end else if (run_q) begin
				cnt_q <= cnt_q - 3'd1;
				if (cnt_q == 3'd0) begin
					run_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= req.num;
			dsh_q <= {req.den, 6'b0};
			quot_q <= '0;
		end else if (run_q) begin
			if (ge) begin
				rem_q <= rem_q - {1'b0, dsh_q};
			end
			quot_q <= {quot_q[IDX_W-2:0], ge};
			dsh_q <= dsh_q >> 1;
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = quot_q;
endmodule

// File: rtl/take_comp_crossfade_mixer_unit.sv
// top level: crossfade mixer with section ring, fade divider and accumulator
// a frame is taken in idle and walks the section ring; a section covering the position
// runs the gain, multiply, product and accumulate states, and each fade window it is in
// first runs the 7-step fade index divider; a frame past the end goes straight to finish
// one item at a time: an entry item is written in idle, the next item is taken in the cycle
// after a result is loaded, and a stalled result holds the block in its final state
// reset (arst_n, asynchronous) restores the register defaults and clears the position
module take_comp_crossfade_mixer_unit import tcm_pkg::*; #(
	parameter int MAX_SECTIONS = MAX_SECTIONS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input in_item_t in_item,
	output logic out_valid,
	input logic out_stall,
	output out_item_t out_item,
	input logic cfg_we,
	input logic [CFG_IDX_W-1:0] cfg_index,
	input logic [POS_W-1:0] cfg_data
);
	`include "take_comp_crossfade_mixer_unit_macros.svh"

	localparam int CNT_W = $clog2(MAX_SECTIONS + 1);
	localparam int IW = (CNT_W > CNT_CFG_W) ? CNT_W : CNT_CFG_W;
	localparam int PROD_W = SAMPLE_BITS + GAIN_W + 1;
	localparam int ACC_W = PROD_W + CNT_W;
	localparam logic signed [ACC_W-1:0] SMAX = ACC_W'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
	localparam logic signed [ACC_W-1:0] SMIN = -SMAX - ACC_W'(1);

	typedef enum logic [11:0] {
		S_IDLE = 12'b000000000001,
		S_LD = 12'b000000000010,
		S_CHK = 12'b000000000100,
		S_DIVI = 12'b000000001000,
		S_DIVO = 12'b000000010000,
		S_GAIN = 12'b000000100000,
		S_MUL = 12'b000001000000,
		S_PROD = 12'b000010000000,
		S_ACC = 12'b000100000000,
		S_NEXT = 12'b001000000000,
		S_WRAP = 12'b010000000000,
		S_FIN = 12'b100000000000
	} state_t;

	state_t state_q;
	logic [HW_W-1:0] hw_q;
	logic [CNT_CFG_W-1:0] cnt_q;
	logic [POS_W-1:0] total_q;
	logic [PRES_W-1:0] pres_q;
	logic [POS_W-1:0] position_q;
	logic [IW-1:0] idx_q;
	logic pe_q, out_valid_q, fin_q, fout_q, bin_q, bout_q, tkok_q;
	out_item_t out_q;
	in_item_t frame_q;
	logic [POS_W-1:0] pos_q, s0_q, s1_q;
	logic [NPH_W-1:0] nin_q, nout_q;
	logic [IDX_W-1:0] qi_q, qo_q;
	logic [GAIN_W-1:0] gin_q, gout_q, gain_q;
	logic signed [PROD_W-1:0] prod_q;
	logic signed [ACC_W-1:0] acc_q;

	entry_t ring [MAX_SECTIONS];
	entry_t head, new_entry;
	logic shift;
	logic entry_wr;
	logic out_load;
	div_req_t dreq;
	div_rsp_t drsp;

	logic [HW_W-1:0] h;
	logic [IW-1:0] cnt_eff;
	logic [POS_W-1:0] rs, re, s0, s1;
	logic [POS_W:0] s1ph, posh;
	logic inr, fin, fout, bin, bout, tkok;
	logic signed [SAMPLE_BITS-1:0] smp;
	logic [2*GAIN_W-1:0] gprod;
	logic signed [ACC_W-1:0] rnd, shr;
	logic [IDX_W-1:0] qo_mirror;

	assign h = (hw_q == '0) ? HW_W'(1) : hw_q;
	assign cnt_eff = (IW'(cnt_q) > IW'(MAX_SECTIONS)) ? IW'(MAX_SECTIONS) : IW'(cnt_q);
	assign head = ring[0];
	assign entry_wr = (state_q == S_IDLE) && in_valid && (in_item.kind == KIND_ENTRY);
	assign new_entry = '{start: in_item.entry_start, stop: in_item.entry_end,
		take: in_item.entry_take};
	assign shift = (state_q == S_NEXT) || (state_q == S_ACC)
		|| ((state_q == S_WRAP) && (idx_q != IW'(MAX_SECTIONS)));
	assign out_load = (state_q == S_FIN) && (!out_valid_q || !out_stall);

	for (genvar k = 0; k < MAX_SECTIONS; k++) begin : g_cell
		tcm_cell u_cell (
			.clk(clk),
			.shift(shift),
			.load(entry_wr && (32'(in_item.entry_slot) == k)),
			.load_entry(new_entry),
			.from_next(ring[(k + 1) % MAX_SECTIONS]),
			.entry(ring[k])
		);
	end

	tcm_div u_div (
		.clk(clk),
		.arst_n(arst_n),
		.req(dreq),
		.rsp(drsp)
	);

	// section geometry of the head cell
	assign s0 = (head.start > total_q) ? total_q : head.start;
	assign s1 = (head.stop > total_q) ? total_q : head.stop;
	assign bin = idx_q != '0;
	assign bout = ({1'b0, idx_q} + (IW + 1)'(1)) < {1'b0, cnt_eff};
	assign tkok = ({1'b0, head.take} < (TAKE_W + 1)'(TAKES)) && pres_q[head.take];

	assign rs = !bin_q ? s0_q : ((s0_q >= POS_W'(h)) ? s0_q - POS_W'(h) : '0);
	assign s1ph = {1'b0, s1_q} + (POS_W + 1)'(h);
	assign re = !bout_q ? s1_q : ((s1ph > {1'b0, total_q}) ? total_q : s1ph[POS_W-1:0]);
	assign posh = {1'b0, pos_q} + (POS_W + 1)'(h);
	assign inr = tkok_q && (pos_q >= rs) && (pos_q < re);
	assign fin = bin_q && (posh < ({1'b0, s0_q} + (POS_W + 1)'(h) + (POS_W + 1)'(h)))
		&& ({1'b0, pos_q} < ({1'b0, s0_q} + (POS_W + 1)'(h)));
	assign fout = bout_q && (posh > {1'b0, s1_q});

	always_comb begin
		dreq.start = 1'b0;
		dreq.num = {nin_q, 6'b0} + DNUM_W'(h);
		dreq.den = {h, 1'b0};
		if (state_q == S_CHK && inr && fin) begin
			dreq.start = 1'b1;
			dreq.num = {NPH_W'(posh - {1'b0, s0_q}), 6'b0} + DNUM_W'(h);
		end else if ((state_q == S_CHK && inr && !fin && fout)
			|| (state_q == S_DIVI && drsp.done && fout_q)) begin
			dreq.start = 1'b1;
			dreq.num = {(state_q == S_CHK) ? NPH_W'(posh - {1'b0, s1_q}) : nout_q, 6'b0}
				+ DNUM_W'(h);
		end
	end

	always_comb begin
		unique case (head.take)
			2'd0: smp = frame_q.sample_take0;
			2'd1: smp = frame_q.sample_take1;
			2'd2: smp = frame_q.sample_take2;
			default: smp = frame_q.sample_take3;
		endcase
	end

	assign qo_mirror = IDX_W'(FADE_STEPS) - qo_q;
	assign gprod = gin_q * gout_q + 32'd16384;
	assign rnd = acc_q + ACC_W'(16384);
	assign shr = rnd >>> 15;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			hw_q <= HW_W'(288);
			cnt_q <= '0;
			total_q <= '0;
			pres_q <= '1;
			position_q <= '0;
			idx_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_HALF_WINDOW: hw_q <= cfg_data[HW_W-1:0];
					CFG_SECTION_COUNT: cnt_q <= cfg_data[CNT_CFG_W-1:0];
					CFG_TOTAL_LENGTH: total_q <= cfg_data;
					CFG_TAKE_PRESENT: pres_q <= cfg_data[PRES_W-1:0];
					default: ;
				endcase
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						if (in_item.kind == KIND_ENTRY) begin
							position_q <= '0;
						end else begin
							if (position_q != POS_MAX) begin
								position_q <= position_q + POS_W'(1);
							end
							idx_q <= '0;
							state_q <= (position_q >= total_q) ? S_FIN : S_LD;
						end
					end
				end
				S_LD: state_q <= (idx_q >= cnt_eff) ? S_WRAP : S_CHK;
				S_CHK: begin
					if (!inr) begin
						state_q <= S_NEXT;
					end else if (fin) begin
						state_q <= S_DIVI;
					end else if (fout) begin
						state_q <= S_DIVO;
					end else begin
						state_q <= S_GAIN;
					end
				end
				S_DIVI: begin
					if (drsp.done) begin
						state_q <= fout_q ? S_DIVO : S_GAIN;
					end
				end
				S_DIVO: begin
					if (drsp.done) begin
						state_q <= S_GAIN;
					end
				end
				S_GAIN: state_q <= S_MUL;
				S_MUL: state_q <= S_PROD;
				S_PROD: state_q <= S_ACC;
				S_ACC, S_NEXT: begin
					idx_q <= idx_q + IW'(1);
					state_q <= S_LD;
				end
				S_WRAP: begin
					if (idx_q == IW'(MAX_SECTIONS)) begin
						idx_q <= '0;
						state_q <= S_FIN;
					end else begin
						idx_q <= idx_q + IW'(1);
					end
				end
				S_FIN: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				frame_q <= in_item;
				pos_q <= position_q;
				acc_q <= '0;
				pe_q <= position_q >= total_q;
			end
			S_LD: begin
				s0_q <= s0;
				s1_q <= s1;
				bin_q <= bin;
				bout_q <= bout;
				tkok_q <= tkok;
			end
			S_CHK: begin
				fin_q <= fin;
				fout_q <= fout;
				nin_q <= NPH_W'(posh - {1'b0, s0_q});
				nout_q <= NPH_W'(posh - {1'b0, s1_q});
			end
			S_DIVI: if (drsp.done) qi_q <= drsp.quot;
			S_DIVO: if (drsp.done) qo_q <= drsp.quot;
			S_GAIN: begin
				gin_q <= fin_q ? SINE_TBL[qi_q] : GAIN_ONE;
				gout_q <= SINE_TBL[qo_mirror];
			end
			S_MUL: gain_q <= fout_q ? gprod[GAIN_W+14:15] : gin_q;
			S_PROD: prod_q <= smp * $signed({1'b0, gain_q});
			S_ACC: acc_q <= acc_q + ACC_W'(prod_q);
			S_FIN: begin
				if (out_load) begin
					if (pe_q) begin
						out_q <= '{mixed_sample: '0, clipped: 1'b0, past_end: 1'b1};
					end else if (shr > SMAX) begin
						out_q <= '{mixed_sample: SMAX[SAMPLE_BITS-1:0], clipped: 1'b1,
							past_end: 1'b0};
					end else if (shr < SMIN) begin
						out_q <= '{mixed_sample: SMIN[SAMPLE_BITS-1:0], clipped: 1'b1,
							past_end: 1'b0};
					end else begin
						out_q <= '{mixed_sample: shr[SAMPLE_BITS-1:0], clipped: 1'b0,
							past_end: 1'b0};
					end
				end
			end
			default: ;
		endcase
	end

	assign in_stall = state_q != S_IDLE;
	assign out_valid = out_valid_q;
	assign out_item = out_q;

	`TCM_ASSERT_NXT(a_frame_starts, in_valid && !in_stall && in_item.kind == KIND_FRAME, state_q == S_LD || state_q == S_FIN)
	`TCM_ASSERT_NXT(a_fin_delivers, state_q == S_FIN && !out_valid_q, out_valid_q)
	`TCM_ASSERT_IMP(a_past_end_zero, out_valid_q && out_q.past_end, out_q.mixed_sample == '0 && !out_q.clipped)
	`TCM_ASSERT_IMP(a_ring_home, state_q == S_IDLE, idx_q == '0)
endmodule
